>>> hw/rtl/tbot_pkg.sv
package tbot_pkg;

    // Field widths
    localparam int COORD_BITS  = 24;
    localparam int NORMAL_BITS = 16;
    localparam int HW_BITS     = COORD_BITS - 1;

    // Box-relative coordinates and edge vectors: one bit above a coordinate
    localparam int U_BITS      = COORD_BITS + 1;
    // Edge-axis arithmetic
    localparam int EPROD_BITS  = 2 * U_BITS;
    localparam int ESUM_BITS   = EPROD_BITS + 1;
    localparam int EABS_BITS   = U_BITS + 1;
    localparam int ERAD_BITS   = HW_BITS + EABS_BITS;
    // Plane arithmetic
    localparam int NPROD_BITS  = NORMAL_BITS + U_BITS;
    localparam int NSUM_BITS   = NPROD_BITS + 2;
    localparam int NABS_BITS   = NORMAL_BITS + 2;
    localparam int NRAD_BITS   = HW_BITS + NABS_BITS;

    localparam logic [HW_BITS-1:0] HW_RESET = HW_BITS'(256);

    typedef logic signed [COORD_BITS-1:0]  coord_t;
    typedef logic signed [NORMAL_BITS-1:0] norm_t;
    typedef logic signed [U_BITS-1:0]      ucoord_t;
    typedef logic        [U_BITS-1:0]      umag_t;
    typedef logic signed [EPROD_BITS-1:0]  eprod_t;
    typedef logic signed [ESUM_BITS-1:0]   esum_t;
    typedef logic        [EABS_BITS-1:0]   eabs_t;
    typedef logic        [ERAD_BITS-1:0]   erad_t;
    typedef logic signed [NPROD_BITS-1:0]  nprod_t;
    typedef logic signed [NSUM_BITS-1:0]   nsum_t;
    typedef logic        [NABS_BITS-1:0]   nabs_t;
    typedef logic        [NRAD_BITS-1:0]   nrad_t;

    typedef struct packed {
        ucoord_t x;
        ucoord_t y;
        ucoord_t z;
    } vec_t;

    // Load enables of the pipeline stages that the edge units share
    typedef struct packed {
        logic s2;
        logic s3;
    } pipe_en_t;

    typedef enum logic [1:0] {
        CFG_CENTER_X = 2'd0,
        CFG_CENTER_Y = 2'd1,
        CFG_CENTER_Z = 2'd2,
        CFG_HALF_W   = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        REJ_NONE   = 4'd0,
        REJ_SLAB_X = 4'd1,
        REJ_SLAB_Y = 4'd2,
        REJ_SLAB_Z = 4'd3,
        REJ_PLANE  = 4'd4,
        REJ_AB_X   = 4'd5,
        REJ_AB_Y   = 4'd6,
        REJ_AB_Z   = 4'd7,
        REJ_BC_X   = 4'd8,
        REJ_BC_Y   = 4'd9,
        REJ_BC_Z   = 4'd10,
        REJ_CA_X   = 4'd11,
        REJ_CA_Y   = 4'd12,
        REJ_CA_Z   = 4'd13
    } reject_t;

    // Magnitude; the most negative value maps to its true magnitude
    function automatic umag_t abs_u(input ucoord_t a);
        ucoord_t n;
        n = -a;
        return a[U_BITS-1] ? umag_t'(n) : umag_t'(a);
    endfunction

endpackage

>>> hw/rtl/triangle_box_overlap_test_unit.sv
// Channel   Handshake          Payload
// s_        s_valid/s_ready    three vertices (Q15.8) and plane normal (Q1.14)
// m_        m_valid/m_ready    m_overlaps, m_reject_stage
// cfg_      cfg_we             cfg_index selects centre x/y/z or half width
//
// One triangle per cycle sustained while m_ready does not stall the result; m_valid
// rises when the item reaches the output register of the last stage. The four
// stages are: offsets and edges, multipliers, sums and radii,
// compare and first-separator select into the output register.
// Each stage has its own valid bit and loads when it is empty or its successor
// moves, so bubbles close up and s_ready only drops once all four stages are full
// and the result is stalled.
// Reset (aresetn, synchronous) empties the pipe and loads centre 0, half width 1.0.
module triangle_box_overlap_test_unit (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [1:0]                       cfg_index,
    input  logic [tbot_pkg::COORD_BITS-1:0]  cfg_wdata,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  tbot_pkg::coord_t                 s_vert_a_x,
    input  tbot_pkg::coord_t                 s_vert_a_y,
    input  tbot_pkg::coord_t                 s_vert_a_z,
    input  tbot_pkg::coord_t                 s_vert_b_x,
    input  tbot_pkg::coord_t                 s_vert_b_y,
    input  tbot_pkg::coord_t                 s_vert_b_z,
    input  tbot_pkg::coord_t                 s_vert_c_x,
    input  tbot_pkg::coord_t                 s_vert_c_y,
    input  tbot_pkg::coord_t                 s_vert_c_z,
    input  tbot_pkg::norm_t                  s_normal_x,
    input  tbot_pkg::norm_t                  s_normal_y,
    input  tbot_pkg::norm_t                  s_normal_z,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_overlaps,
    output logic [3:0]                       m_reject_stage
);
    import tbot_pkg::*;

    // ---------------------------------------------------------------- config
    coord_t               ctr_x_reg;
    coord_t               ctr_y_reg;
    coord_t               ctr_z_reg;
    logic [HW_BITS-1:0]   hw_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctr_x_reg <= '0;
            ctr_y_reg <= '0;
            ctr_z_reg <= '0;
            hw_reg    <= HW_RESET;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_index))
                CFG_CENTER_X: ctr_x_reg <= coord_t'(cfg_wdata);
                CFG_CENTER_Y: ctr_y_reg <= coord_t'(cfg_wdata);
                CFG_CENTER_Z: ctr_z_reg <= coord_t'(cfg_wdata);
                CFG_HALF_W:   hw_reg    <= cfg_wdata[HW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------- flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------- stage 1: box-relative verts, edges
    vec_t   u_reg, v_reg, w_reg;
    vec_t   eab_reg, ebc_reg, eca_reg;
    norm_t  nx_reg, ny_reg, nz_reg;
    nabs_t  nabs_reg;

    function automatic ucoord_t csub(input coord_t a, input coord_t b);
        return ucoord_t'(a) - ucoord_t'(b);
    endfunction

    function automatic nabs_t nmag(input norm_t a);
        norm_t n;
        n = -a;
        return a[NORMAL_BITS-1] ? nabs_t'(unsigned'(n)) : nabs_t'(unsigned'(a));
    endfunction

    always_ff @(posedge aclk) begin
        if (adv1) begin
            u_reg    <= '{csub(s_vert_a_x, ctr_x_reg), csub(s_vert_a_y, ctr_y_reg),
                          csub(s_vert_a_z, ctr_z_reg)};
            v_reg    <= '{csub(s_vert_b_x, ctr_x_reg), csub(s_vert_b_y, ctr_y_reg),
                          csub(s_vert_b_z, ctr_z_reg)};
            w_reg    <= '{csub(s_vert_c_x, ctr_x_reg), csub(s_vert_c_y, ctr_y_reg),
                          csub(s_vert_c_z, ctr_z_reg)};
            // edges need no centre: it cancels
            eab_reg  <= '{csub(s_vert_b_x, s_vert_a_x), csub(s_vert_b_y, s_vert_a_y),
                          csub(s_vert_b_z, s_vert_a_z)};
            ebc_reg  <= '{csub(s_vert_c_x, s_vert_b_x), csub(s_vert_c_y, s_vert_b_y),
                          csub(s_vert_c_z, s_vert_b_z)};
            eca_reg  <= '{csub(s_vert_a_x, s_vert_c_x), csub(s_vert_a_y, s_vert_c_y),
                          csub(s_vert_a_z, s_vert_c_z)};
            nx_reg   <= s_normal_x;
            ny_reg   <= s_normal_y;
            nz_reg   <= s_normal_z;
            nabs_reg <= nmag(s_normal_x) + nmag(s_normal_y) + nmag(s_normal_z);
        end
    end

    // ------------------------------- stage 2: slab flags, plane products, radius
    ucoord_t      hw_s;
    ucoord_t      hw_n;
    logic [2:0]   slab_sep;
    logic [2:0]   slab2_reg, slab3_reg;
    nprod_t       npx_reg, npy_reg, npz_reg;
    nrad_t        nrad2_reg, nrad3_reg;
    nsum_t        d_reg;

    function automatic logic slab_out(input ucoord_t a, input ucoord_t b, input ucoord_t c,
                                      input ucoord_t hi, input ucoord_t lo);
        return ((a < lo) && (b < lo) && (c < lo)) || ((a > hi) && (b > hi) && (c > hi));
    endfunction

    always_comb begin
        hw_s        = ucoord_t'(hw_reg);
        hw_n        = -hw_s;
        slab_sep[0] = slab_out(u_reg.x, v_reg.x, w_reg.x, hw_s, hw_n);
        slab_sep[1] = slab_out(u_reg.y, v_reg.y, w_reg.y, hw_s, hw_n);
        slab_sep[2] = slab_out(u_reg.z, v_reg.z, w_reg.z, hw_s, hw_n);
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            slab2_reg <= slab_sep;
            npx_reg   <= nprod_t'(nx_reg) * nprod_t'(u_reg.x);
            npy_reg   <= nprod_t'(ny_reg) * nprod_t'(u_reg.y);
            npz_reg   <= nprod_t'(nz_reg) * nprod_t'(u_reg.z);
            nrad2_reg <= nrad_t'(hw_reg) * nrad_t'(nabs_reg);
        end
        // ---------------------------------- stage 3: plane distance
        if (adv3) begin
            slab3_reg <= slab2_reg;
            d_reg     <= nsum_t'(npx_reg) + nsum_t'(npy_reg) + nsum_t'(npz_reg);
            nrad3_reg <= nrad2_reg;
        end
    end

    // --------------------------------------------- edge axes (stages 2 and 3)
    pipe_en_t    edge_en;
    logic [2:0]  sep_ab, sep_bc, sep_ca;

    assign edge_en = '{s2: adv2, s3: adv3};

    tbot_edge_unit u_edge_ab (
        .aclk (aclk), .en (edge_en), .p0 (u_reg), .p2 (w_reg), .e (eab_reg),
        .hw (hw_reg), .sep (sep_ab)
    );

    tbot_edge_unit u_edge_bc (
        .aclk (aclk), .en (edge_en), .p0 (v_reg), .p2 (u_reg), .e (ebc_reg),
        .hw (hw_reg), .sep (sep_bc)
    );

    tbot_edge_unit u_edge_ca (
        .aclk (aclk), .en (edge_en), .p0 (w_reg), .p2 (v_reg), .e (eca_reg),
        .hw (hw_reg), .sep (sep_ca)
    );

    // ------------------------------ stage 4: compare, first separator wins
    nsum_t    nr_s;
    nsum_t    nr_n;
    logic     plane_sep;
    reject_t  rej_next;
    reject_t  rej_reg;
    logic     ovl_reg;

    always_comb begin
        nr_s      = nsum_t'(nrad3_reg);
        nr_n      = -nr_s;
        plane_sep = (d_reg < nr_n) || (d_reg > nr_s);

        if      (slab3_reg[0]) rej_next = REJ_SLAB_X;
        else if (slab3_reg[1]) rej_next = REJ_SLAB_Y;
        else if (slab3_reg[2]) rej_next = REJ_SLAB_Z;
        else if (plane_sep)    rej_next = REJ_PLANE;
        else if (sep_ab[0])    rej_next = REJ_AB_X;
        else if (sep_ab[1])    rej_next = REJ_AB_Y;
        else if (sep_ab[2])    rej_next = REJ_AB_Z;
        else if (sep_bc[0])    rej_next = REJ_BC_X;
        else if (sep_bc[1])    rej_next = REJ_BC_Y;
        else if (sep_bc[2])    rej_next = REJ_BC_Z;
        else if (sep_ca[0])    rej_next = REJ_CA_X;
        else if (sep_ca[1])    rej_next = REJ_CA_Y;
        else if (sep_ca[2])    rej_next = REJ_CA_Z;
        else                   rej_next = REJ_NONE;
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            rej_reg <= rej_next;
            ovl_reg <= (rej_next == REJ_NONE);
        end
    end

    assign m_valid        = v4_reg;
    assign m_overlaps     = ovl_reg;
    assign m_reject_stage = rej_reg;

    // -------------------------------------------------------------- checks
    a_ovl_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_overlaps == (m_reject_stage == REJ_NONE)))
        else $error("overlap flag disagrees with reject code");

    a_code_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_reject_stage <= REJ_CA_Z))
        else $error("reject code out of range");

    a_ready_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_ready))
        else $error("input stalled while pipeline has a bubble");

    a_no_invent: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v3_reg && adv4) |=> !m_valid)
        else $error("result appeared without an item behind it");

endmodule

>>> hw/rtl/tbot_edge_unit.sv
module tbot_edge_unit (
    input  logic                          aclk,
    input  tbot_pkg::pipe_en_t            en,
    input  tbot_pkg::vec_t                p0,
    input  tbot_pkg::vec_t                p2,
    input  tbot_pkg::vec_t                e,
    input  logic [tbot_pkg::HW_BITS-1:0]  hw,
    output logic [2:0]                    sep
);
    import tbot_pkg::*;

    // Axis k: p = m1*b1 - m2*b2 (and likewise q on p2), radius hw*(|m1|+|m2|)
    ucoord_t m1 [3];
    ucoord_t m2 [3];
    ucoord_t b1 [3];
    ucoord_t b2 [3];
    ucoord_t c1 [3];
    ucoord_t c2 [3];

    eprod_t pb1_reg [3];
    eprod_t pb2_reg [3];
    eprod_t pc1_reg [3];
    eprod_t pc2_reg [3];
    eabs_t  asum_reg [3];

    esum_t  p_reg [3];
    esum_t  q_reg [3];
    erad_t  r_reg [3];

    always_comb begin
        // edge x x axis
        m1[0] = e.z;  m2[0] = e.y;  b1[0] = p0.y; b2[0] = p0.z; c1[0] = p2.y; c2[0] = p2.z;
        // edge x y axis
        m1[1] = e.x;  m2[1] = e.z;  b1[1] = p0.z; b2[1] = p0.x; c1[1] = p2.z; c2[1] = p2.x;
        // edge x z axis
        m1[2] = e.y;  m2[2] = e.x;  b1[2] = p0.x; b2[2] = p0.y; c1[2] = p2.x; c2[2] = p2.y;
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < 3; k++) begin
            if (en.s2) begin
                pb1_reg[k]  <= eprod_t'(m1[k]) * eprod_t'(b1[k]);
                pb2_reg[k]  <= eprod_t'(m2[k]) * eprod_t'(b2[k]);
                pc1_reg[k]  <= eprod_t'(m1[k]) * eprod_t'(c1[k]);
                pc2_reg[k]  <= eprod_t'(m2[k]) * eprod_t'(c2[k]);
                asum_reg[k] <= eabs_t'(abs_u(m1[k])) + eabs_t'(abs_u(m2[k]));
            end
            if (en.s3) begin
                p_reg[k] <= esum_t'(pb1_reg[k]) - esum_t'(pb2_reg[k]);
                q_reg[k] <= esum_t'(pc1_reg[k]) - esum_t'(pc2_reg[k]);
                r_reg[k] <= erad_t'(hw) * erad_t'(asum_reg[k]);
            end
        end
    end

    always_comb begin
        esum_t rs;
        esum_t nrs;
        for (int k = 0; k < 3; k++) begin
            rs     = esum_t'(r_reg[k]);
            nrs    = -rs;
            sep[k] = ((p_reg[k] < nrs) && (q_reg[k] < nrs)) ||
                     ((p_reg[k] > rs) && (q_reg[k] > rs));
        end
    end

endmodule
